### src/thrbeta_pkg.sv
// ---------------------------------------------------------------------------
// Thermistor Beta temperature package
// Widths, fixed-point constants, request/result types and the ln table.
// ---------------------------------------------------------------------------
package thrbeta_pkg;

  localparam int ADC_BITS  = 12;
  localparam int RES_W     = 20;
  localparam int TREF_W    = 16;
  localparam int BETA_W    = 15;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W     = 20;

  localparam int PROD_W  = RES_W + ADC_BITS;
  localparam int K_W     = $clog2(PROD_W);
  localparam int FRAC_W  = 16;
  localparam int IDX_W   = 4;
  localparam int REM_W   = 12;
  localparam int LN_W    = 22;
  localparam int LNR_W   = LN_W + 1;
  localparam int TB_W    = TREF_W + BETA_W;
  localparam int M_W     = LNR_W + TREF_W + 1;
  localparam int DEN_W   = M_W + 1;
  localparam int DIV_W   = DEN_W - 1;
  localparam int NUM_W   = TB_W + 23;
  localparam int DVD_W   = NUM_W + 1;
  localparam int Q_W     = 17;
  localparam int CMP_W   = DIV_W + Q_W;
  localparam int TEMP_W  = 16;
  localparam int LATENCY = 28;

  localparam logic [ADC_BITS-1:0] CODE_FS = '1;
  localparam int LN2_Q16       = 45426;
  localparam int SCALE_Q16     = 6553600;
  localparam int KELVIN_OFFSET = 27315;
  localparam int TEMP_MAX      = 32767;
  localparam int TQ_MAX        = TEMP_MAX + KELVIN_OFFSET;

  typedef enum logic [1:0] {
    FAULT_OK    = 2'd0,
    FAULT_OPEN  = 2'd1,
    FAULT_SHORT = 2'd2,
    FAULT_SAT   = 2'd3
  } fault_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_R1_A   = 4'd0,
    REG_R0_A   = 4'd1,
    REG_T0_A   = 4'd2,
    REG_BETA_A = 4'd3,
    REG_R1_B   = 4'd4,
    REG_R0_B   = 4'd5,
    REG_T0_B   = 4'd6,
    REG_BETA_B = 4'd7
  } reg_index_t;

  typedef struct packed {
    logic [ADC_BITS-1:0] adc_code;
    logic                sensor_select;
  } request_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_centi_c;
    fault_t                   fault;
    logic                     sensor_echo;
  } result_t;

  typedef struct packed {
    logic   sensor_select;
    fault_t pre_fault;
  } tag_t;

  // ln(1 + i/16) in Q0.16
  function automatic logic [15:0] ln_table(input logic [IDX_W:0] idx);
    logic [15:0] val;
    case (idx)
      5'd0:    val = 16'd0;
      5'd1:    val = 16'd3973;
      5'd2:    val = 16'd7719;
      5'd3:    val = 16'd11262;
      5'd4:    val = 16'd14624;
      5'd5:    val = 16'd17821;
      5'd6:    val = 16'd20870;
      5'd7:    val = 16'd23783;
      5'd8:    val = 16'd26573;
      5'd9:    val = 16'd29248;
      5'd10:   val = 16'd31818;
      5'd11:   val = 16'd34292;
      5'd12:   val = 16'd36675;
      5'd13:   val = 16'd38975;
      5'd14:   val = 16'd41197;
      5'd15:   val = 16'd43345;
      5'd16:   val = 16'd45426;
      default: val = 16'd0;
    endcase
    return val;
  endfunction

endpackage

### src/thrbeta_ln.sv
// ---------------------------------------------------------------------------
// Pipelined natural log
// ln(v) in Q6.16: leading one, normalize, table plus interpolation, sum.
// ---------------------------------------------------------------------------
module thrbeta_ln (
  input  logic                            clk,
  input  logic [thrbeta_pkg::PROD_W-1:0]  value,
  output logic [thrbeta_pkg::LN_W-1:0]    ln_q16
);

  logic [thrbeta_pkg::K_W-1:0]    k1_next;
  logic [thrbeta_pkg::K_W-1:0]    k1;
  logic [thrbeta_pkg::PROD_W-1:0] v1;

  logic [thrbeta_pkg::K_W-1:0]    shamt;
  logic [thrbeta_pkg::PROD_W-1:0] norm;
  logic [thrbeta_pkg::FRAC_W-1:0] frac;
  logic [thrbeta_pkg::K_W-1:0]    k2;
  logic [thrbeta_pkg::IDX_W-1:0]  idx2;
  logic [thrbeta_pkg::REM_W-1:0]  rem2;

  logic [15:0]                    lo_next;
  logic [15:0]                    hi_next;
  logic [15:0]                    diff;
  logic [thrbeta_pkg::LN_W-1:0]   kln3;
  logic [15:0]                    lo3;
  logic [23:0]                    prod3;

  always_comb begin
    k1_next = '0;
    for (int i = 1; i < thrbeta_pkg::PROD_W; i++) begin
      if (value[i]) begin
        k1_next = thrbeta_pkg::K_W'(i);
      end
    end
  end

  assign shamt = thrbeta_pkg::K_W'(thrbeta_pkg::PROD_W - 1) - k1;
  assign norm  = v1 << shamt;
  assign frac  = norm[thrbeta_pkg::PROD_W-2 -: thrbeta_pkg::FRAC_W];

  assign lo_next = thrbeta_pkg::ln_table({1'b0, idx2});
  assign hi_next = thrbeta_pkg::ln_table({1'b0, idx2} + 5'd1);
  assign diff    = hi_next - lo_next;

  always_ff @(posedge clk) begin
    k1     <= k1_next;
    v1     <= value;
    k2     <= k1;
    idx2   <= frac[thrbeta_pkg::FRAC_W-1 -: thrbeta_pkg::IDX_W];
    rem2   <= frac[thrbeta_pkg::REM_W-1:0];
    kln3   <= thrbeta_pkg::LN_W'(k2) * thrbeta_pkg::LN_W'(thrbeta_pkg::LN2_Q16);
    lo3    <= lo_next;
    prod3  <= diff[11:0] * rem2;
    ln_q16 <= kln3 + thrbeta_pkg::LN_W'(lo3) + thrbeta_pkg::LN_W'(prod3[23:12]);
  end

endmodule

### src/thrbeta_div.sv
// ---------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, with an overflow flag for quotients too wide.
// ---------------------------------------------------------------------------
module thrbeta_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic [thrbeta_pkg::DVD_W-1:0]   dividend,
  input  logic [thrbeta_pkg::DIV_W-1:0]   divisor,
  input  thrbeta_pkg::tag_t               in_tag,
  output logic                            out_valid,
  output logic [thrbeta_pkg::Q_W-1:0]     quotient,
  output logic                            overflow,
  output thrbeta_pkg::tag_t               out_tag
);

  localparam int NS = thrbeta_pkg::Q_W;

  logic                            vld [0:NS];
  logic [thrbeta_pkg::CMP_W-1:0]   rem [0:NS];
  logic [thrbeta_pkg::DIV_W-1:0]   dvs [0:NS];
  logic [thrbeta_pkg::Q_W-1:0]     quo [0:NS];
  logic                            ovf [0:NS];
  thrbeta_pkg::tag_t               tag [0:NS];

  logic [thrbeta_pkg::CMP_W-1:0]   limit;

  assign limit = {divisor, {thrbeta_pkg::Q_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem[0] <= thrbeta_pkg::CMP_W'(dividend);
    dvs[0] <= divisor;
    quo[0] <= '0;
    ovf[0] <= thrbeta_pkg::CMP_W'(dividend) >= limit;
    tag[0] <= in_tag;
  end

  for (genvar j = 1; j <= NS; j++) begin : g_stage
    logic [thrbeta_pkg::CMP_W-1:0] trial;
    logic                          take;

    assign trial = thrbeta_pkg::CMP_W'(dvs[j-1]) << (NS - j);
    assign take  = rem[j-1] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else begin
        vld[j] <= vld[j-1];
      end
    end

    always_ff @(posedge clk) begin
      rem[j]        <= take ? rem[j-1] - trial : rem[j-1];
      dvs[j]        <= dvs[j-1];
      quo[j]        <= quo[j-1] | (thrbeta_pkg::Q_W'(take) << (NS - j));
      ovf[j]        <= ovf[j-1];
      tag[j]        <= tag[j-1];
    end
  end

  assign out_valid = vld[NS];
  assign quotient  = quo[NS];
  assign overflow  = ovf[NS];
  assign out_tag   = tag[NS];

endmodule

### src/thermistor_beta_temperature.sv
// ---------------------------------------------------------------------------
// Thermistor Beta-equation temperature converter
// ADC code of an NTC divider to temperature in 0.01 degC, two sensor sets.
//
//  channel   signals                           dir  handshake
//  request   start, busy, request              in   start & !busy
//  result    done, result                      out  done strobe, one cycle
//  config    cfg_valid, cfg_ready, cfg_index,  in   cfg_valid & cfg_ready
//            cfg_data
//
// One request per cycle; each result passes through the ln pipeline, product
// stages, then one quotient bit per divider stage.
// busy stays low and cfg_ready stays high. Results leave in request order.
// Reset clears the pipeline valid bits and loads default constants.
// ---------------------------------------------------------------------------
module thermistor_beta_temperature (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  thrbeta_pkg::request_t               request,
  output logic                                done,
  output thrbeta_pkg::result_t                result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [thrbeta_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [thrbeta_pkg::CFG_W-1:0]       cfg_data
);

  // constant sets, index 0 sensor A, 1 sensor B
  logic [thrbeta_pkg::RES_W-1:0]  r1_reg   [0:1];
  logic [thrbeta_pkg::RES_W-1:0]  r0_reg   [0:1];
  logic [thrbeta_pkg::TREF_W-1:0] t0_reg   [0:1];
  logic [thrbeta_pkg::BETA_W-1:0] beta_reg [0:1];

  logic                           accept;
  logic                           sel;
  logic [thrbeta_pkg::ADC_BITS-1:0] code;
  logic [thrbeta_pkg::RES_W-1:0]  r1_sel;
  logic [thrbeta_pkg::RES_W-1:0]  r0_sel;
  logic [thrbeta_pkg::TREF_W-1:0] t0_sel;
  logic [thrbeta_pkg::BETA_W-1:0] beta_sel;
  thrbeta_pkg::tag_t              tag_next;
  thrbeta_pkg::tag_t              tag_chk;

  logic                           vld [1:9];
  thrbeta_pkg::tag_t              tag [1:9];

  logic [thrbeta_pkg::PROD_W-1:0] prod_top1;
  logic [thrbeta_pkg::PROD_W-1:0] prod_bot1;
  logic [thrbeta_pkg::TREF_W-1:0] t0_d [1:6];
  logic [thrbeta_pkg::BETA_W-1:0] beta1;
  logic [thrbeta_pkg::BETA_W-1:0] beta2;
  logic [thrbeta_pkg::TB_W-1:0]   tb2;
  logic [thrbeta_pkg::NUM_W-1:0]  num_d [3:8];
  logic [thrbeta_pkg::DIV_W-1:0]  bb_d  [3:7];

  logic [thrbeta_pkg::LN_W-1:0]   ln_top;
  logic [thrbeta_pkg::LN_W-1:0]   ln_bot;
  logic signed [thrbeta_pkg::LNR_W-1:0] lnr6;
  logic signed [thrbeta_pkg::M_W-1:0]   m7;
  logic signed [thrbeta_pkg::DEN_W-1:0] den8;
  logic                           den_nonpos;
  logic [thrbeta_pkg::DVD_W-1:0]  dvd9;
  logic [thrbeta_pkg::DIV_W-1:0]  den9;

  logic                           q_valid;
  logic [thrbeta_pkg::Q_W-1:0]    q;
  logic                           q_ovf;
  thrbeta_pkg::tag_t              q_tag;
  thrbeta_pkg::result_t           result_next;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_reg[0]   <= thrbeta_pkg::RES_W'(10000);
      r0_reg[0]   <= thrbeta_pkg::RES_W'(10000);
      t0_reg[0]   <= thrbeta_pkg::TREF_W'(29815);
      beta_reg[0] <= thrbeta_pkg::BETA_W'(3950);
      r1_reg[1]   <= thrbeta_pkg::RES_W'(10000);
      r0_reg[1]   <= thrbeta_pkg::RES_W'(10000);
      t0_reg[1]   <= thrbeta_pkg::TREF_W'(29815);
      beta_reg[1] <= thrbeta_pkg::BETA_W'(3950);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        thrbeta_pkg::REG_R1_A:   r1_reg[0]   <= cfg_data;
        thrbeta_pkg::REG_R0_A:   r0_reg[0]   <= cfg_data;
        thrbeta_pkg::REG_T0_A:   t0_reg[0]   <= cfg_data[thrbeta_pkg::TREF_W-1:0];
        thrbeta_pkg::REG_BETA_A: beta_reg[0] <= cfg_data[thrbeta_pkg::BETA_W-1:0];
        thrbeta_pkg::REG_R1_B:   r1_reg[1]   <= cfg_data;
        thrbeta_pkg::REG_R0_B:   r0_reg[1]   <= cfg_data;
        thrbeta_pkg::REG_T0_B:   t0_reg[1]   <= cfg_data[thrbeta_pkg::TREF_W-1:0];
        thrbeta_pkg::REG_BETA_B: beta_reg[1] <= cfg_data[thrbeta_pkg::BETA_W-1:0];
        default: ;
      endcase
    end
  end

  // zero constants act as one
  assign sel      = request.sensor_select;
  assign code     = request.adc_code;
  assign r1_sel   = (r1_reg[sel] == '0) ? thrbeta_pkg::RES_W'(1) : r1_reg[sel];
  assign r0_sel   = (r0_reg[sel] == '0) ? thrbeta_pkg::RES_W'(1) : r0_reg[sel];
  assign t0_sel   = (t0_reg[sel] == '0) ? thrbeta_pkg::TREF_W'(1) : t0_reg[sel];
  assign beta_sel = (beta_reg[sel] == '0) ? thrbeta_pkg::BETA_W'(1) : beta_reg[sel];

  always_comb begin
    tag_next.sensor_select = sel;
    if (code == thrbeta_pkg::CODE_FS) begin
      tag_next.pre_fault = thrbeta_pkg::FAULT_OPEN;
    end else if (code == '0) begin
      tag_next.pre_fault = thrbeta_pkg::FAULT_SHORT;
    end else begin
      tag_next.pre_fault = thrbeta_pkg::FAULT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= 9; i++) begin
        vld[i] <= 1'b0;
      end
    end else begin
      vld[1] <= accept;
      for (int i = 2; i <= 9; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  assign den_nonpos = den8[thrbeta_pkg::DEN_W-1] | (den8 == '0);

  always_comb begin
    tag_chk = tag[8];
    if (tag[8].pre_fault == thrbeta_pkg::FAULT_OK && den_nonpos) begin
      tag_chk.pre_fault = thrbeta_pkg::FAULT_SAT;
    end
  end

  always_ff @(posedge clk) begin
    tag[1] <= tag_next;
    for (int i = 2; i <= 8; i++) begin
      tag[i] <= tag[i-1];
    end
    tag[9] <= tag_chk;

    prod_top1 <= thrbeta_pkg::PROD_W'(r1_sel) * thrbeta_pkg::PROD_W'(code);
    prod_bot1 <= thrbeta_pkg::PROD_W'(r0_sel)
               * thrbeta_pkg::PROD_W'(thrbeta_pkg::CODE_FS - code);
    t0_d[1]   <= t0_sel;
    beta1     <= beta_sel;
    for (int i = 2; i <= 6; i++) begin
      t0_d[i] <= t0_d[i-1];
    end

    tb2      <= thrbeta_pkg::TB_W'(t0_d[1]) * thrbeta_pkg::TB_W'(beta1);
    beta2    <= beta1;
    num_d[3] <= thrbeta_pkg::NUM_W'(tb2) * thrbeta_pkg::NUM_W'(thrbeta_pkg::SCALE_Q16);
    bb_d[3]  <= thrbeta_pkg::DIV_W'(beta2) * thrbeta_pkg::DIV_W'(thrbeta_pkg::SCALE_Q16);
    for (int i = 4; i <= 8; i++) begin
      num_d[i] <= num_d[i-1];
    end
    for (int i = 4; i <= 7; i++) begin
      bb_d[i] <= bb_d[i-1];
    end

    lnr6 <= $signed({1'b0, ln_top}) - $signed({1'b0, ln_bot});
    m7   <= lnr6 * $signed({1'b0, t0_d[6]});
    den8 <= $signed({1'b0, bb_d[7]}) + thrbeta_pkg::DEN_W'(m7);
    dvd9 <= thrbeta_pkg::DVD_W'(num_d[8])
          + thrbeta_pkg::DVD_W'(den8[thrbeta_pkg::DEN_W-2:1]);
    den9 <= den8[thrbeta_pkg::DIV_W-1:0];
  end

  thrbeta_ln u_ln_top (
    .clk    (clk),
    .value  (prod_top1),
    .ln_q16 (ln_top)
  );

  thrbeta_ln u_ln_bot (
    .clk    (clk),
    .value  (prod_bot1),
    .ln_q16 (ln_bot)
  );

  thrbeta_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld[9]),
    .dividend  (dvd9),
    .divisor   (den9),
    .in_tag    (tag[9]),
    .out_valid (q_valid),
    .quotient  (q),
    .overflow  (q_ovf),
    .out_tag   (q_tag)
  );

  always_comb begin
    result_next.sensor_echo = q_tag.sensor_select;
    case (q_tag.pre_fault)
      thrbeta_pkg::FAULT_OPEN: begin
        result_next.fault        = thrbeta_pkg::FAULT_OPEN;
        result_next.temp_centi_c = -thrbeta_pkg::TEMP_W'(thrbeta_pkg::KELVIN_OFFSET);
      end
      thrbeta_pkg::FAULT_SHORT: begin
        result_next.fault        = thrbeta_pkg::FAULT_SHORT;
        result_next.temp_centi_c = thrbeta_pkg::TEMP_W'(thrbeta_pkg::TEMP_MAX);
      end
      thrbeta_pkg::FAULT_SAT: begin
        result_next.fault        = thrbeta_pkg::FAULT_SAT;
        result_next.temp_centi_c = thrbeta_pkg::TEMP_W'(thrbeta_pkg::TEMP_MAX);
      end
      default: begin
        if (q_ovf || q > thrbeta_pkg::Q_W'(thrbeta_pkg::TQ_MAX)) begin
          result_next.fault        = thrbeta_pkg::FAULT_SAT;
          result_next.temp_centi_c = thrbeta_pkg::TEMP_W'(thrbeta_pkg::TEMP_MAX);
        end else begin
          result_next.fault        = thrbeta_pkg::FAULT_OK;
          result_next.temp_centi_c = thrbeta_pkg::TEMP_W'(
            q - thrbeta_pkg::Q_W'(thrbeta_pkg::KELVIN_OFFSET));
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

### src/thrbeta_chk.sv
// ---------------------------------------------------------------------------
// Thermistor converter port checker
// Fixed latency, ordering of sensor echo, open-circuit result value, config writes.
// ---------------------------------------------------------------------------
module thrbeta_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input thrbeta_pkg::request_t             request,
  input logic                              done,
  input thrbeta_pkg::result_t              result,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [thrbeta_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [thrbeta_pkg::CFG_W-1:0]     cfg_data
);

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##28 done)
    else $error("request without result after fixed latency");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, thrbeta_pkg::LATENCY))
    else $error("result without matching request");

  a_echo: assert property (@(posedge clk) disable iff (rst)
    done |-> result.sensor_echo == $past(request.sensor_select, thrbeta_pkg::LATENCY))
    else $error("sensor echo mismatch");

  a_open: assert property (@(posedge clk) disable iff (rst)
    (done && result.fault == thrbeta_pkg::FAULT_OPEN)
      |-> result.temp_centi_c == -16'sd27315)
    else $error("open sensor result not at absolute zero");

  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready && !$isunknown({cfg_index, cfg_data}))
    else $error("config write not taken or unknown");

endmodule

bind thermistor_beta_temperature thrbeta_chk u_thrbeta_chk (.*);

### tb/sv/thermistor_beta_temperature_test.sv
// ---------------------------------------------------------------------------
// Thermistor Beta temperature converter testbench
// Sends ADC codes for both sensors under several constant sets, predicts
// each temperature in fixed point and checks every result strobe in order.
// ---------------------------------------------------------------------------
class temp_scoreboard;

  logic [19:0] regs [8];
  thrbeta_pkg::result_t expected_temps [$];
  int mismatches;

  function new();
    reset_regs();
    mismatches = 0;
  endfunction

  function void reset_regs();
    regs[thrbeta_pkg::REG_R1_A]   = 20'd10000;
    regs[thrbeta_pkg::REG_R0_A]   = 20'd10000;
    regs[thrbeta_pkg::REG_T0_A]   = 20'd29815;
    regs[thrbeta_pkg::REG_BETA_A] = 20'd3950;
    regs[thrbeta_pkg::REG_R1_B]   = 20'd10000;
    regs[thrbeta_pkg::REG_R0_B]   = 20'd10000;
    regs[thrbeta_pkg::REG_T0_B]   = 20'd29815;
    regs[thrbeta_pkg::REG_BETA_B] = 20'd3950;
  endfunction

  function void write_reg(logic [3:0] idx, logic [19:0] data);
    case (idx)
      thrbeta_pkg::REG_T0_A, thrbeta_pkg::REG_T0_B: regs[idx] = data & 20'hFFFF;
      thrbeta_pkg::REG_BETA_A, thrbeta_pkg::REG_BETA_B: regs[idx] = data & 20'h7FFF;
      thrbeta_pkg::REG_R1_A, thrbeta_pkg::REG_R0_A,
      thrbeta_pkg::REG_R1_B, thrbeta_pkg::REG_R0_B: regs[idx] = data;
      default: ;
    endcase
  endfunction

  function longint log_fix(longint unsigned v);
    int ln_frac [17] = '{0, 3973, 7719, 11262, 14624, 17821, 20870, 23783, 26573,
                         29248, 31818, 34292, 36675, 38975, 41197, 43345, 45426};
    int k;
    longint unsigned t;
    longint unsigned sh;
    longint frac, idx, rem, lo, hi;
    if (v == 0) v = 1;
    k = 0;
    t = v;
    while (t > 1) begin
      t >>= 1;
      k++;
    end
    sh = v << (63 - k);
    frac = (sh >> 47) & 64'hFFFF;
    idx = frac >> 12;
    rem = frac & 64'hFFF;
    lo = ln_frac[idx];
    hi = ln_frac[idx + 1];
    return longint'(k) * thrbeta_pkg::LN2_Q16 + lo + (((hi - lo) * rem) >>> 12);
  endfunction

  function longint unsigned nonzero(logic [19:0] x);
    return (x == 0) ? 1 : longint'(x);
  endfunction

  function void note_request(thrbeta_pkg::request_t req);
    thrbeta_pkg::result_t res;
    longint unsigned code, r1, r0;
    longint t0, beta, lnr, num, den, temp;
    int base;
    code = req.adc_code;
    base = req.sensor_select ? 4 : 0;
    res.sensor_echo = req.sensor_select;
    if (req.adc_code == thrbeta_pkg::CODE_FS) begin
      temp = -thrbeta_pkg::KELVIN_OFFSET;
      res.fault = thrbeta_pkg::FAULT_OPEN;
    end else if (code == 0) begin
      temp = thrbeta_pkg::TEMP_MAX;
      res.fault = thrbeta_pkg::FAULT_SHORT;
    end else begin
      r1 = nonzero(regs[base]);
      r0 = nonzero(regs[base + 1]);
      t0 = nonzero(regs[base + 2]);
      beta = nonzero(regs[base + 3]);
      lnr = log_fix(r1 * code) - log_fix((4095 - code) * r0);
      num = 100 * t0 * beta * 65536;
      den = longint'(thrbeta_pkg::SCALE_Q16) * beta + lnr * t0;
      res.fault = thrbeta_pkg::FAULT_OK;
      if (den <= 0) begin
        temp = thrbeta_pkg::TEMP_MAX;
        res.fault = thrbeta_pkg::FAULT_SAT;
      end else begin
        temp = (num + den / 2) / den - thrbeta_pkg::KELVIN_OFFSET;
        if (temp > thrbeta_pkg::TEMP_MAX) begin
          temp = thrbeta_pkg::TEMP_MAX;
          res.fault = thrbeta_pkg::FAULT_SAT;
        end
      end
    end
    res.temp_centi_c = temp[15:0];
    expected_temps.push_back(res);
  endfunction

  function void check_result(thrbeta_pkg::result_t got);
    thrbeta_pkg::result_t want;
    if (expected_temps.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    want = expected_temps.pop_front();
    if (got.temp_centi_c !== want.temp_centi_c || got.fault !== want.fault ||
        got.sensor_echo !== want.sensor_echo) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: temp %0d/%0d fault %0d/%0d sensor %0d/%0d (exp/act)",
                 want.temp_centi_c, got.temp_centi_c, want.fault, got.fault,
                 want.sensor_echo, got.sensor_echo);
    end
  endfunction

endclass

module thermistor_beta_temperature_test;

  logic clk = 0;
  logic rst;
  logic start;
  logic busy;
  thrbeta_pkg::request_t request;
  logic done;
  thrbeta_pkg::result_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [thrbeta_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [thrbeta_pkg::CFG_W-1:0] cfg_data;

  temp_scoreboard sb = new();
  int cycles = 0;
  int idle_pct = 0;

  always #6 clk = ~clk;

  thermistor_beta_temperature u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
    cycles <= cycles + 1;
    if (cycles > 100000) begin
      $display("thermistor_beta_temperature_test failed");
      $finish;
    end
  end

  task automatic send_code(logic [11:0] code, logic sel);
    thrbeta_pkg::request_t req;
    req.adc_code = code;
    req.sensor_select = sel;
    start <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    sb.note_request(req);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.expected_temps.size() != 0) @(posedge clk);
    repeat (thrbeta_pkg::LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [3:0] idx, logic [19:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_set(int base, logic [19:0] r1, logic [19:0] r0,
                           logic [19:0] t0, logic [19:0] beta);
    write_cfg(4'(base), r1);
    write_cfg(4'(base + 1), r0);
    write_cfg(4'(base + 2), t0);
    write_cfg(4'(base + 3), beta);
  endtask

  task automatic random_codes(int n);
    logic [11:0] code;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(19))
        0: code = 12'd0;
        1: code = 12'hFFF;
        2: code = 12'($urandom_range(15));
        3: code = 12'(12'hFFF - $urandom_range(15, 1));
        default: code = 12'($urandom_range(4094, 1));
      endcase
      send_code(code, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    request <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes and faults on reset constants
    for (int b = 0; b < thrbeta_pkg::ADC_BITS; b++) send_code(12'd1 << b, 1'(b % 2));
    send_code(12'd0, 1'b0);
    send_code(12'd0, 1'b1);
    send_code(12'hFFF, 1'b0);
    send_code(12'hFFF, 1'b1);
    send_code(12'd1, 1'b0);
    send_code(12'hFFE, 1'b1);
    send_code(12'd2048, 1'b0);
    send_code(12'd2047, 1'b1);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_set(0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
          write_set(4, 20'd0, 20'd0, 20'd0, 20'd0);
        end
        1: begin
          write_set(0, 20'd1, 20'd1000000, 20'd65535, 20'd1);
          write_set(4, 20'd1000000, 20'd1, 20'd1, 20'd20000);
          write_cfg(4'd8, 20'd123);
          write_cfg(4'd15, 20'hFFFFF);
        end
        default: begin
          write_set(0, 20'($urandom_range(1000000, 1)), 20'($urandom_range(1000000, 1)),
                    20'($urandom_range(65535, 1)), 20'($urandom_range(20000, 1)));
          write_set(4, 20'($urandom_range(100000, 100)), 20'($urandom_range(100000, 100)),
                    20'($urandom_range(40000, 20000)), 20'($urandom_range(5000, 2000)));
          write_cfg(4'($urandom_range(15, 8)), 20'($urandom()));
        end
      endcase
      idle_pct = (phase < 2) ? 23 : (phase < 4) ? 45 : 0;
      random_codes(200);
      drain();
    end

    if (sb.mismatches == 0 && sb.expected_temps.size() == 0)
      $display("thermistor_beta_temperature_test passed");
    else
      $display("thermistor_beta_temperature_test failed");
    $finish;
  end

endmodule
